// ===== hdl/rtl_pkg.sv =====
// Shared types and constants for the regen torque limiter.
package rtl_pkg;

    localparam int NUM_W  = 50;   // electrical numerator: V * I * 768 * 2^16
    localparam int DEN_W  = 33;   // electrical denominator: pi_q16 * rpm
    localparam int QUO_W  = 17;   // quotient bits resolved by the cell row
    localparam int CREM_W = 26;   // charge numerator shifted up by 16
    localparam int CDEN_W = 10;
    localparam int GAIN_W = 17;   // Q16 gains, up to and including one

    localparam logic [17:0]       PI_Q16   = 18'd205887;
    localparam logic [GAIN_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [15:0]       V_OFFSET = 16'd50;
    localparam logic [15:0]       MIN_RPM  = 16'sd9;

    typedef enum logic [2:0] {
        REG_VOLTAGE_CAP  = 3'd0,
        REG_TORQUE_CAP   = 3'd1,
        REG_CHARGE_CURR  = 3'd2,
        REG_FADE_SPEED   = 3'd3,
        REG_CHARGE_START = 3'd4,
        REG_CHARGE_FULL  = 3'd5,
        REG_TEMP_LIMIT   = 3'd6,
        REG_USER_GAIN    = 3'd7
    } rtl_reg_idx_t;

    // Word passed from one divider cell to the next.
    typedef struct packed {
        logic [NUM_W-1:0]  rem;
        logic [DEN_W-1:0]  den;
        logic [QUO_W-1:0]  quo;
        logic [CREM_W-1:0] crem;
        logic [CDEN_W-1:0] cden;
        logic [QUO_W-1:0]  cquo;
        logic              slow;
        logic              fade;
        logic              over;
        logic              czero;
        logic              cone;
        logic [GAIN_W-1:0] tgain;
    } rtl_cell_t;

endpackage

// ===== hdl/regen_torque_limiter.sv =====
// Top level of the regen torque limiter: input staging, divider cell row and gain stages.
// Each input word carries one sample (bus voltage, signed shaft speed, hottest cell
// temperature, charge level) and yields exactly one output word with the regen torque
// and the electrical limit, both Q8.8 Nm. A new word is taken every cycle while the pipeline
// advances; each sample passes three front stages (voltage clamp and current product,
// numerator and denominator products with the temperature table read, overflow test),
// seventeen divider cells that each settle one quotient bit of V*I/omega and of the
// charge gain, a stage that applies the torque cap and the fade cut and selects the
// charge gain, two stages for the charge and temperature gain products, and the output
// register, which applies the user gain and saturates. The pipeline advances whenever
// the output register is empty or being taken, so s_tready drops only while a finished
// word waits downstream.
// The user must write configuration registers via cfg_we, cfg_index and cfg_wdata only while
// no sample is in flight (the block does not enforce this); the temperature table is a constant built at elaboration.
module regen_torque_limiter #(
    parameter int TEMP_TABLE_DEPTH = 512,
    parameter int SHARPNESS_MILLI  = 500
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Sample words. s_tdata from bit 0: bus_voltage_raw[15:0], shaft_speed_rpm[15:0],
    // cell_temp_dc[15:0], charge_level_pm[9:0], six zero bits.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    // Result words. m_tdata from bit 0: regen_torque_q8[15:0], electrical_max_q8[15:0].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_wdata
);
    import rtl_pkg::*;

    localparam int IDX_W = $clog2(TEMP_TABLE_DEPTH);
    localparam int NCELL = QUO_W;
    localparam logic [63:0] SeriesDiv = 64'd10000;

    typedef logic [GAIN_W-1:0] rom_t [TEMP_TABLE_DEPTH];

    // Restoring long division, used only while the constant tables are built.
    function automatic logic [63:0] const_quot(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], a[i]};
            if (rem >= {1'b0, b}) begin
                rem    = rem - {1'b0, b};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Q30 sum of 24 truncated terms of the exponential series.
    function automatic logic [63:0] exp_sum();
        logic [63:0] term;
        logic [63:0] sum;
        term = 64'd1 << 30;
        sum  = 64'd1 << 30;
        for (int n = 1; n < 24; n++) begin
            term = const_quot(term * 64'(SHARPNESS_MILLI), SeriesDiv * 64'(n));
            sum  = sum + term;
        end
        return sum;
    endfunction

    localparam logic [63:0] EXP_SUM = exp_sum();
    localparam logic [63:0] DECAY   = (64'd1 << 60) / EXP_SUM;

    // Gain table: one minus a decaying exponential, in Q16.
    function automatic rom_t build_rom(input logic [63:0] r);
        rom_t        rom;
        logic [63:0] p;
        logic [63:0] q16;
        p = 64'd1 << 30;
        for (int i = 0; i < TEMP_TABLE_DEPTH; i++) begin
            q16 = (p + (64'd1 << 13)) >> 14;
            rom[i] = (q16 >= 64'(ONE_Q16)) ? '0 : GAIN_W'(64'(ONE_Q16) - q16);
            p = (p * r + (64'd1 << 29)) >> 30;
        end
        return rom;
    endfunction

    localparam rom_t TEMP_ROM = build_rom(DECAY);

    // Configuration registers.
    logic [15:0] vcap_reg;
    logic [15:0] tcap_reg;
    logic [7:0]  icharge_reg;
    logic [14:0] fade_reg;
    logic [9:0]  cstart_reg;
    logic [9:0]  cfull_reg;
    logic [15:0] tlimit_reg;
    logic [16:0] ugain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcap_reg    <= 16'd5100;
            tcap_reg    <= 16'd25600;
            icharge_reg <= 8'd20;
            fade_reg    <= 15'd500;
            cstart_reg  <= 10'd950;
            cfull_reg   <= 10'd900;
            tlimit_reg  <= 16'd450;
            ugain_reg   <= 17'd65536;
        end else if (cfg_we) begin
            case (rtl_reg_idx_t'(cfg_index))
                REG_VOLTAGE_CAP:  vcap_reg    <= cfg_wdata[15:0];
                REG_TORQUE_CAP:   tcap_reg    <= cfg_wdata[15:0];
                REG_CHARGE_CURR:  icharge_reg <= cfg_wdata[7:0];
                REG_FADE_SPEED:   fade_reg    <= cfg_wdata[14:0];
                REG_CHARGE_START: cstart_reg  <= cfg_wdata[9:0];
                REG_CHARGE_FULL:  cfull_reg   <= cfg_wdata[9:0];
                REG_TEMP_LIMIT:   tlimit_reg  <= cfg_wdata[15:0];
                REG_USER_GAIN:    ugain_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The whole pipeline moves together unless a finished word is held at the output.
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Front stage one: voltage clamp, current product, speed, temperature and charge tests.
    logic [15:0]        raw;
    logic signed [15:0] rpm;
    logic [15:0]        temp;
    logic [9:0]         lvl;
    logic [15:0]        v_off;
    logic [15:0]        v_clamped;
    logic signed [16:0] tdiff;
    logic signed [10:0] cnum;
    logic signed [10:0] cden;
    logic [9:0]         cnum_abs;
    logic [9:0]         cden_abs;

    logic               p1_valid_reg;
    logic [23:0]        p1_vi_reg;
    logic [14:0]        p1_rpm_reg;
    logic               p1_slow_reg;
    logic               p1_fade_reg;
    logic               p1_tzero_reg;
    logic [IDX_W-1:0]   p1_idx_reg;
    logic [9:0]         p1_cnum_reg;
    logic [9:0]         p1_cden_reg;
    logic               p1_czero_reg;
    logic               p1_cone_reg;

    always_comb begin
        raw       = s_tdata[15:0];
        rpm       = $signed(s_tdata[31:16]);
        temp      = s_tdata[47:32];
        lvl       = s_tdata[57:48];
        v_off     = (raw >= V_OFFSET) ? raw - V_OFFSET : '0;
        v_clamped = (v_off > vcap_reg) ? vcap_reg : v_off;
        tdiff     = $signed({1'b0, tlimit_reg}) - $signed({1'b0, temp});
        cnum      = $signed({1'b0, lvl}) - $signed({1'b0, cstart_reg});
        cden      = $signed({1'b0, cfull_reg}) - $signed({1'b0, cstart_reg});
        cnum_abs  = cnum[10] ? 10'(-cnum) : cnum[9:0];
        cden_abs  = cden[10] ? 10'(-cden) : cden[9:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= s_tvalid;
        end
        if (en) begin
            p1_vi_reg    <= 24'(v_clamped * icharge_reg);
            p1_rpm_reg   <= rpm[14:0];
            p1_slow_reg  <= rpm <= $signed(MIN_RPM);
            p1_fade_reg  <= rpm < $signed({1'b0, fade_reg});
            p1_tzero_reg <= tdiff <= 17'sd0;
            p1_idx_reg   <= (tdiff >= $signed(17'(TEMP_TABLE_DEPTH)))
                            ? IDX_W'(TEMP_TABLE_DEPTH - 1) : tdiff[IDX_W-1:0];
            p1_cnum_reg  <= cnum_abs;
            p1_cden_reg  <= cden_abs;
            p1_czero_reg <= (cden == 11'sd0) || (cnum == 11'sd0) || (cnum[10] != cden[10]);
            p1_cone_reg  <= cnum_abs >= cden_abs;
        end
    end

    // Front stage two: numerator, denominator and the temperature gain table read.
    logic               p2_valid_reg;
    logic [NUM_W-1:0]   p2_num_reg;
    logic [DEN_W-1:0]   p2_den_reg;
    logic [GAIN_W-1:0]  p2_tgain_reg;
    logic               p2_slow_reg;
    logic               p2_fade_reg;
    logic [9:0]         p2_cnum_reg;
    logic [9:0]         p2_cden_reg;
    logic               p2_czero_reg;
    logic               p2_cone_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p2_valid_reg <= p1_valid_reg;
        end
        if (en) begin
            p2_num_reg   <= NUM_W'({1'b0, p1_vi_reg, 1'b0} + {2'b0, p1_vi_reg}) << 24;
            p2_den_reg   <= DEN_W'(PI_Q16 * p1_rpm_reg);
            p2_tgain_reg <= p1_tzero_reg ? '0 : TEMP_ROM[p1_idx_reg];
            p2_slow_reg  <= p1_slow_reg;
            p2_fade_reg  <= p1_fade_reg;
            p2_cnum_reg  <= p1_cnum_reg;
            p2_cden_reg  <= p1_cden_reg;
            p2_czero_reg <= p1_czero_reg;
            p2_cone_reg  <= p1_cone_reg;
        end
    end

    // Front stage three: a quotient of 2^17 or more saturates to the torque cap.
    rtl_cell_t chain_word [NCELL+1];
    logic      chain_valid [NCELL+1];
    rtl_cell_t p3_word_reg;
    logic      p3_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
        end else if (en) begin
            p3_valid_reg <= p2_valid_reg;
        end
        if (en) begin
            p3_word_reg.rem   <= p2_num_reg;
            p3_word_reg.den   <= p2_den_reg;
            p3_word_reg.quo   <= '0;
            p3_word_reg.crem  <= {p2_cnum_reg, 16'd0};
            p3_word_reg.cden  <= p2_cden_reg;
            p3_word_reg.cquo  <= '0;
            p3_word_reg.slow  <= p2_slow_reg;
            p3_word_reg.fade  <= p2_fade_reg;
            p3_word_reg.over  <= p2_num_reg >= {p2_den_reg, 17'd0};
            p3_word_reg.czero <= p2_czero_reg;
            p3_word_reg.cone  <= p2_cone_reg;
            p3_word_reg.tgain <= p2_tgain_reg;
        end
    end

    assign chain_word[0]  = p3_word_reg;
    assign chain_valid[0] = p3_valid_reg;

    // Divider row: the cell at position j settles quotient bit NCELL-1-j.
    for (genvar j = 0; j < NCELL; j++) begin : g_cell
        rtl_div_cell #(
            .K(NCELL - 1 - j)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (chain_valid[j]),
            .in_word  (chain_word[j]),
            .out_valid(chain_valid[j+1]),
            .out_word (chain_word[j+1])
        );
    end

    // Gain stage A: electrical limit, fade cut and charge gain selection.
    rtl_cell_t         dw;
    logic [15:0]       elec;
    logic              a_valid_reg;
    logic [15:0]       a_torque_reg;
    logic [15:0]       a_elec_reg;
    logic [GAIN_W-1:0] a_cgain_reg;
    logic [GAIN_W-1:0] a_tgain_reg;

    always_comb begin
        dw = chain_word[NCELL];
        if (dw.slow) begin
            elec = '0;
        end else if (dw.over || (dw.quo > QUO_W'(tcap_reg))) begin
            elec = tcap_reg;
        end else begin
            elec = dw.quo[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= chain_valid[NCELL];
        end
        if (en) begin
            a_torque_reg <= dw.fade ? '0 : elec;
            a_elec_reg   <= elec;
            a_cgain_reg  <= dw.czero ? '0 : (dw.cone ? ONE_Q16 : {1'b0, dw.cquo[15:0]});
            a_tgain_reg  <= dw.tgain;
        end
    end

    // Gain stage B: charge gain product.
    logic [32:0]       b_prod;
    logic              b_valid_reg;
    logic [15:0]       b_torque_reg;
    logic [15:0]       b_elec_reg;
    logic [GAIN_W-1:0] b_tgain_reg;

    assign b_prod = a_torque_reg * a_cgain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
        if (en) begin
            b_torque_reg <= b_prod[31:16];
            b_elec_reg   <= a_elec_reg;
            b_tgain_reg  <= a_tgain_reg;
        end
    end

    // Gain stage C: temperature gain product.
    logic [32:0] c_prod;
    logic        c_valid_reg;
    logic [15:0] c_torque_reg;
    logic [15:0] c_elec_reg;

    assign c_prod = b_torque_reg * b_tgain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= b_valid_reg;
        end
        if (en) begin
            c_torque_reg <= c_prod[31:16];
            c_elec_reg   <= b_elec_reg;
        end
    end

    // Output register: user gain product with saturation.
    logic [32:0] d_prod;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    assign d_prod = c_torque_reg * ugain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= c_valid_reg;
        end
        if (en) begin
            out_data_reg <= {c_elec_reg, d_prod[32] ? 16'hFFFF : d_prod[31:16]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The electrical limit never exceeds the torque cap.
    a_elec_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:16] <= tcap_reg))
        else $error("electrical limit above torque cap");

    // With a user gain of at most one, the torque never exceeds the electrical limit.
    a_torque_le_elec: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (ugain_reg <= ONE_Q16)) |-> (m_tdata[15:0] <= m_tdata[31:16]))
        else $error("regen torque above electrical limit");

    // A word leaving the divider row reaches stage A on the next advancing edge.
    a_row_to_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && chain_valid[NCELL]) |=> a_valid_reg)
        else $error("word lost after divider row");

endmodule

// ===== hdl/rtl_div_cell.sv =====
// One restoring-division cell: resolves quotient bit K of both dividers.
module rtl_div_cell #(
    parameter int K = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  rtl_pkg::rtl_cell_t in_word,
    output logic              out_valid,
    output rtl_pkg::rtl_cell_t out_word
);
    import rtl_pkg::*;

    logic [NUM_W-1:0]  dsh;
    logic [CREM_W-1:0] csh;
    logic              ge;
    logic              cge;
    rtl_cell_t         word_next;
    rtl_cell_t         word_reg;
    logic              valid_reg;

    always_comb begin
        dsh = NUM_W'(in_word.den) << K;
        csh = CREM_W'(in_word.cden) << K;
        ge  = in_word.rem >= dsh;
        cge = in_word.crem >= csh;
        word_next = in_word;
        if (ge) begin
            word_next.rem = in_word.rem - dsh;
        end
        if (cge) begin
            word_next.crem = in_word.crem - csh;
        end
        word_next.quo[K]  = ge;
        word_next.cquo[K] = cge;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;
endmodule

// ===== tb/regen_torque_limiter_checker.sv =====
// Checker for the regen torque limiter: shadow registers, prediction and result comparison.
`timescale 1ns / 1ps
module regen_torque_limiter_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_wdata,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);
    import rtl_pkg::*;

    localparam int ROM_DEPTH = 512;
    localparam int SHARP     = 500;

    typedef struct packed {
        logic [15:0] torque;
        logic [15:0] elec;
    } torque_word_t;

    logic [15:0] sh_vcap, sh_tcap, sh_tlim;
    logic [7:0]  sh_curr;
    logic [14:0] sh_fade;
    logic [9:0]  sh_cstart, sh_cfull;
    logic [16:0] sh_ugain;
    logic [31:0] derate_rom [ROM_DEPTH];
    torque_word_t torque_queue[$];

    initial begin
        logic [63:0] term, total, ratio, p, q16;
        term  = 64'd1 << 30;
        total = term;
        for (int n = 1; n < 24; n++) begin
            term  = (term * SHARP) / (64'd10000 * n);
            total += term;
        end
        ratio = (64'd1 << 60) / total;
        p = 64'd1 << 30;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            q16 = (p + (64'd1 << 13)) >> 14;
            derate_rom[i] = (q16 >= 64'd65536) ? 32'd0 : 32'(64'd65536 - q16);
            p = (p * ratio + (64'd1 << 29)) >> 30;
        end
    end

    function automatic logic [63:0] soc_gain(logic [9:0] level);
        int num, den;
        logic [63:0] g;
        num = int'(level) - int'(sh_cstart);
        den = int'(sh_cfull) - int'(sh_cstart);
        if (den == 0 || num == 0 || ((num < 0) != (den < 0)))
            return 0;
        if (num < 0) begin
            num = -num;
            den = -den;
        end
        g = (64'(num) << 16) / 64'(den);
        return (g > 64'd65536) ? 64'd65536 : g;
    endfunction

    function automatic logic [63:0] thermal_gain(logic [15:0] temp);
        int d;
        d = int'(sh_tlim) - int'(temp);
        if (d <= 0)
            return 0;
        if (d >= ROM_DEPTH)
            d = ROM_DEPTH - 1;
        return 64'(derate_rom[d]);
    endfunction

    function automatic torque_word_t predict_torque(logic [63:0] w);
        logic [15:0] raw, temp;
        logic signed [15:0] rpm;
        logic [9:0]  level;
        logic [63:0] v, elec, t;
        torque_word_t r;
        raw   = w[15:0];
        rpm   = w[31:16];
        temp  = w[47:32];
        level = w[57:48];
        elec  = 0;
        if (rpm > 16'sd9) begin
            v = (raw >= 16'd50) ? 64'(raw - 16'd50) : 64'd0;
            if (v > sh_vcap)
                v = 64'(sh_vcap);
            elec = (v * sh_curr * 64'd768 * 64'd65536) / (64'd205887 * 64'(rpm));
            if (elec > sh_tcap)
                elec = 64'(sh_tcap);
        end
        t = elec;
        if (int'(rpm) < int'(sh_fade))
            t = 0;
        t = (t * soc_gain(level)) >> 16;
        t = (t * thermal_gain(temp)) >> 16;
        t = (t * sh_ugain) >> 16;
        if (t > 64'hFFFF)
            t = 64'hFFFF;
        r.torque = t[15:0];
        r.elec   = elec[15:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        torque_word_t exp_w;
        if (!aresetn) begin
            sh_vcap <= 16'd5100; sh_tcap <= 16'd25600; sh_curr <= 8'd20;
            sh_fade <= 15'd500;  sh_cstart <= 10'd950; sh_cfull <= 10'd900;
            sh_tlim <= 16'd450;  sh_ugain <= 17'd65536;
            torque_queue.delete();
            fail_count    <= 0;
            result_count  <= 0;
            pending_count <= 0;
        end else begin
            if (cfg_we) begin
                case (rtl_reg_idx_t'(cfg_index))
                    REG_VOLTAGE_CAP:  sh_vcap   <= cfg_wdata[15:0];
                    REG_TORQUE_CAP:   sh_tcap   <= cfg_wdata[15:0];
                    REG_CHARGE_CURR:  sh_curr   <= cfg_wdata[7:0];
                    REG_FADE_SPEED:   sh_fade   <= cfg_wdata[14:0];
                    REG_CHARGE_START: sh_cstart <= cfg_wdata[9:0];
                    REG_CHARGE_FULL:  sh_cfull  <= cfg_wdata[9:0];
                    REG_TEMP_LIMIT:   sh_tlim   <= cfg_wdata[15:0];
                    REG_USER_GAIN:    sh_ugain  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                torque_queue.push_back(predict_torque(s_tdata));
            if (m_tvalid && m_tready) begin
                result_count <= result_count + 1;
                if (torque_queue.size() == 0) begin
                    $error("Unexpected result word %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_w = torque_queue.pop_front();
                    if (m_tdata[15:0] !== exp_w.torque || m_tdata[31:16] !== exp_w.elec)
                        fail_count <= fail_count + 1;
                    if (m_tdata[15:0] !== exp_w.torque)
                        $error("regen_torque_q8: expected %0d, got %0d",
                               exp_w.torque, m_tdata[15:0]);
                    if (m_tdata[31:16] !== exp_w.elec)
                        $error("electrical_max_q8: expected %0d, got %0d",
                               exp_w.elec, m_tdata[31:16]);
                end
            end
            pending_count <= torque_queue.size();
        end
    end

endmodule

// ===== tb/regen_torque_limiter_tb.sv =====
// Stimulus and verdict for the regen torque limiter testbench.
`timescale 1ns / 1ps
module regen_torque_limiter_tb;
    import rtl_pkg::*;

    // Settle time before register writes, once all results are in.
    localparam int SETTLE_CYCLES = 40;
    // Cycles without any accepted word before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_wdata;
    int          fail_count;
    int          pending_count;
    int          result_count;
    int          idle_cycles;
    int          sample_count;
    int          config_count;

    regen_torque_limiter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    regen_torque_limiter_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Gap lengths: usually none or short, now and then a long stretch.
    function automatic int pick_gap(int mode);
        int roll;
        roll = $urandom_range(0, 99);
        if (mode == 0)
            return 0;
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Gap mode per phase: 0 runs back to back, 1 inserts random idles.
    int src_mode;
    int sink_mode;

    // The result side stalls on its own schedule.
    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            stall = pick_gap(sink_mode);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Watchdog: any accepted word on either side resets the idle count.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d words outstanding", pending_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // One register write; the write port then idles before the task returns.
    task automatic write_reg(rtl_reg_idx_t idx, logic [16:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
        config_count++;
    endtask

    // Waits for all results, then lets the pipeline drain before touching registers.
    task automatic drain_pipeline();
        while (pending_count != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Offers one sample and holds it until the block takes it.
    task automatic send_sample(logic [15:0] raw, logic [15:0] rpm, logic [15:0] temp,
                               logic [9:0] level);
        int gap;
        gap = pick_gap(src_mode);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, level, temp, rpm, raw};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
        sample_count++;
    endtask

    // Random sample biased toward the interesting regions of each field.
    task automatic send_random_sample();
        logic [15:0] raw, rpm, temp;
        logic [9:0]  level;
        int          roll;
        roll = $urandom_range(0, 9);
        raw  = (roll < 2) ? 16'($urandom) : 16'($urandom_range(0, 6000));
        roll = $urandom_range(0, 9);
        if (roll < 1)
            rpm = 16'($urandom);
        else if (roll < 3)
            rpm = 16'($urandom_range(0, 20));
        else
            rpm = 16'($urandom_range(10, 12000));
        roll = $urandom_range(0, 9);
        temp = (roll < 2) ? 16'($urandom) : 16'($urandom_range(0, 1200));
        level = 10'($urandom_range(0, 1000));
        send_sample(raw, rpm, temp, level);
    endtask

    // Directed corners: extremes of every field plus each special case.
    task automatic send_directed();
        send_sample(16'd5150, 16'd1000, 16'd300, 10'd920);    // typical, mid charge gain
        send_sample(16'd5150, 16'd9, 16'd300, 10'd800);       // speed at slow threshold
        send_sample(16'd5150, 16'd10, 16'd300, 10'd800);      // just above slow threshold
        send_sample(16'd5150, 16'h8000, 16'd300, 10'd800);    // most negative speed
        send_sample(16'd5150, 16'hFFFF, 16'd300, 10'd800);    // reverse speed
        send_sample(16'd5150, 16'h7FFF, 16'd300, 10'd800);    // top speed
        send_sample(16'd5150, 16'd499, 16'd300, 10'd800);     // just below fade speed
        send_sample(16'd5150, 16'd500, 16'd300, 10'd800);     // at fade speed
        send_sample(16'd0, 16'd1000, 16'd300, 10'd800);       // bus below offset
        send_sample(16'd49, 16'd1000, 16'd300, 10'd800);
        send_sample(16'd50, 16'd1000, 16'd300, 10'd800);
        send_sample(16'hFFFF, 16'd1000, 16'd300, 10'd800);    // bus above cap
        send_sample(16'd5150, 16'd1000, 16'd450, 10'd800);    // at temperature limit
        send_sample(16'd5150, 16'd1000, 16'hFFFF, 10'd800);   // far above limit
        send_sample(16'd5150, 16'd1000, 16'd449, 10'd800);    // table entry one
        send_sample(16'd5150, 16'd1000, 16'd0, 10'd800);      // coldest cell, largest table index
        send_sample(16'd5150, 16'd1000, 16'd300, 10'd0);      // charge gain one
        send_sample(16'd5150, 16'd1000, 16'd300, 10'd1000);   // charge gain zero
        send_sample(16'd5150, 16'd1000, 16'd300, 10'd950);
        send_sample(16'd5150, 16'd1000, 16'd300, 10'd900);
        send_sample(16'd5150, 16'd20, 16'd100, 10'd500);      // large electrical limit
    endtask

    // Writes a full random register setting; some fields get extremes.
    task automatic write_random_setting();
        write_reg(REG_VOLTAGE_CAP, ($urandom_range(0, 3) == 0) ? 17'hFFFF
                                   : 17'($urandom_range(0, 8000)));
        write_reg(REG_TORQUE_CAP, 17'($urandom));
        write_reg(REG_CHARGE_CURR, 17'($urandom_range(0, 255)));
        write_reg(REG_FADE_SPEED, 17'($urandom_range(0, 3000)));
        write_reg(REG_CHARGE_START, 17'($urandom_range(0, 1000)));
        write_reg(REG_CHARGE_FULL, 17'($urandom_range(0, 1000)));
        write_reg(REG_TEMP_LIMIT, 17'($urandom_range(0, 1500)));
        write_reg(REG_USER_GAIN, ($urandom_range(0, 3) == 0) ? 17'd65536
                                 : 17'($urandom_range(0, 65536)));
    endtask

    initial begin
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_we       = 1'b0;
        cfg_index    = REG_VOLTAGE_CAP;
        cfg_wdata    = '0;
        aresetn      = 1'b0;
        src_mode     = 0;
        sink_mode    = 0;
        sample_count = 0;
        config_count = 0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Reset values first, back to back, then with idles.
        send_directed();
        src_mode  = 1;
        sink_mode = 1;
        send_directed();
        s_tvalid <= 1'b0;
        drain_pipeline();

        // Extremes: every register but the charge breakpoints at its top, including user gain above one.
        write_reg(REG_VOLTAGE_CAP, 17'h1FFFF);
        write_reg(REG_TORQUE_CAP, 17'hFFFF);
        write_reg(REG_CHARGE_CURR, 17'hFF);
        write_reg(REG_FADE_SPEED, 17'h7FFF);
        write_reg(REG_CHARGE_START, 17'd0);
        write_reg(REG_CHARGE_FULL, 17'd1000);
        write_reg(REG_TEMP_LIMIT, 17'hFFFF);
        write_reg(REG_USER_GAIN, 17'h1FFFF);
        send_directed();
        s_tvalid <= 1'b0;
        drain_pipeline();

        // Zero fade speed, equal charge breakpoints, zero limits.
        write_reg(REG_FADE_SPEED, 17'd0);
        write_reg(REG_CHARGE_START, 17'd500);
        write_reg(REG_CHARGE_FULL, 17'd500);
        write_reg(REG_TEMP_LIMIT, 17'd0);
        write_reg(REG_VOLTAGE_CAP, 17'd0);
        send_directed();
        s_tvalid <= 1'b0;
        drain_pipeline();
        write_reg(REG_CHARGE_FULL, 17'd0);
        write_reg(REG_TEMP_LIMIT, 17'd2000);
        write_reg(REG_VOLTAGE_CAP, 17'd6000);
        write_reg(REG_USER_GAIN, 17'd0);
        write_reg(REG_CHARGE_CURR, 17'd0);
        write_reg(REG_TORQUE_CAP, 17'd0);
        send_directed();
        s_tvalid <= 1'b0;
        drain_pipeline();

        // Random phases, each with a fresh setting and its own idle pattern.
        for (int phase = 0; phase < 8; phase++) begin
            write_random_setting();
            src_mode  = (phase % 3 == 0) ? 0 : 1;
            sink_mode = (phase % 4 == 1) ? 0 : 1;
            for (int k = 0; k < 190; k++)
                send_random_sample();
            s_tvalid <= 1'b0;
            drain_pipeline();
        end

        $display("Sent %0d samples and checked %0d results across %0d register writes.",
                 sample_count, result_count, config_count);
        $display("Covered slow, fade, bus, charge and temperature corners plus random phases.");
        if (fail_count == 0 && pending_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
